FILE: src/sprite_quad_setup_top_assert.svh
// Assertion macros for the sprite quad setup back end.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef SPRITE_QUAD_SETUP_TOP_ASSERT_SVH
`define SPRITE_QUAD_SETUP_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SQS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SQS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sqs_pkg.sv
// Shared types, constants and corner tables for the sprite quad setup block.
// No dependencies.
package sqs_pkg;

    localparam int ANGLE_BITS_DEF  = 10;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Quarter-turn sine polynomial coefficients, Q1.14.
    localparam logic [14:0] SIN_A = 15'd25736;
    localparam logic [13:0] SIN_B = 14'd10512;
    localparam logic [10:0] SIN_C = 11'd1160;

    typedef enum logic [1:0] {
        MODE_FLAT       = 2'd0,
        MODE_ROT_ASPECT = 2'd1,
        MODE_ROT_DIM    = 2'd2,
        MODE_ROT_FADE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CFG_NEAR_CLIP = 3'd0,
        CFG_FAR_CLIP  = 3'd1,
        CFG_SCR_W     = 3'd2,
        CFG_SCR_H     = 3'd3,
        CFG_NEAR_SD   = 3'd4,
        CFG_FAR_SD    = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [23:0] near_clip;
        logic [23:0] far_clip;
        logic [12:0] scr_w;
        logic [12:0] scr_h;
        logic [23:0] near_sd;
        logic [23:0] far_sd;
    } cfg_t;

    // One kept sprite on its way from the front end to the vertex emitter.
    typedef struct packed {
        logic [3:0][23:0] xs;
        logic [3:0][23:0] ys;
        logic [23:0]      z;
        logic [23:0]      rz;
        logic [31:0]      rgba;
    } sprite_t;

    typedef struct packed {
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] sd;
        logic [23:0] cz;
        logic [23:0] rz;
        logic [31:0] rgba;
        logic        u;
        logic        v;
        logic        last;
    } vertex_t;

    // Triangle-list order of the corners: 0,1,2,3,0,2.
    function automatic logic [1:0] corner_of(input logic [2:0] beat);
        logic [1:0] c;
        case (beat)
            3'd0:    c = 2'd0;
            3'd1:    c = 2'd1;
            3'd2:    c = 2'd2;
            3'd3:    c = 2'd3;
            3'd4:    c = 2'd0;
            3'd5:    c = 2'd2;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

    function automatic logic corner_u(input logic [1:0] c);
        return c[1];
    endfunction

    function automatic logic corner_v(input logic [1:0] c);
        return c[1] ^ c[0];
    endfunction

endpackage

FILE: src/sqs_front.sv
// Front end: fade, sine and cosine, corner placement and screen cull.
// Depends on sqs_pkg. Feeds kept sprites into the queue.
module sqs_front import sqs_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            in_mode,
    input  logic [23:0]           in_x,
    input  logic [23:0]           in_y,
    input  logic [23:0]           in_z,
    input  logic [22:0]           in_w,
    input  logic [22:0]           in_h,
    input  logic [23:0]           in_rgb,
    input  logic [7:0]            in_inten,
    input  logic [23:0]           in_rz,
    input  logic [ANGLE_BITS-1:0] in_angle,
    input  logic [7:0]            in_alpha,
    input  logic                  q_full,
    output logic                  q_push,
    output sprite_t               q_data
);

    localparam int NST       = 8;
    localparam int FADE_LO   = ((13 << FRAC_BITS) + 5) / 10;
    localparam int FADE_HI   = ((23 << FRAC_BITS) + 5) / 10;
    localparam int FADE_SPAN = FADE_HI - FADE_LO;
    localparam int NW        = FRAC_BITS + 10;
    localparam int FK        = 2 * FRAC_BITS + 10;
    localparam int RW        = FRAC_BITS + 12;
    localparam logic [RW-1:0] FRECIP =
        RW'(((64'd1 << FK) + 64'(FADE_SPAN) - 64'd1) / 64'(FADE_SPAN));

    typedef struct packed {
        logic [1:0]       mode;
        logic             fade;
        logic             drop;
        logic [23:0]      x;
        logic [23:0]      y;
        logic [23:0]      z;
        logic [22:0]      w;
        logic [22:0]      h;
        logic [23:0]      rz;
        logic [7:0]       alpha;
        logic [7:0]       rc;
        logic [7:0]       gc;
        logic [7:0]       bc;
        logic [7:0]       inten;
        logic [15:0]      phase;
        logic [NW-1:0]    n;
        logic [7:0]       f;
        logic [14:0]      ts;
        logic [14:0]      tc;
        logic             neg_s;
        logic             neg_c;
        logic [14:0]      t2s;
        logic [14:0]      t2c;
        logic [13:0]      p1s;
        logic [13:0]      p1c;
        logic [14:0]      p2s;
        logic [14:0]      p2c;
        logic [15:0]      sn;
        logic [15:0]      cs;
        logic [25:0]      m0;
        logic [25:0]      m1;
        logic [25:0]      m2;
        logic [25:0]      m3;
        logic [31:0]      rgba;
        logic [3:0][27:0] xs;
        logic [3:0][27:0] ys;
    } pipe_t;

    pipe_t            st_reg [NST];
    pipe_t            st_next [NST];
    logic [NST-1:0]   vld_reg;
    logic             en;
    logic             keep;
    logic             cull;
    logic [15:0]      ph_c;
    logic [FRAC_BITS+1:0] fdz;
    logic [29:0]      sq_s, sq_c;
    logic [NW+RW-1:0] fprod;
    logic [24:0]      cp_s, cp_c;
    logic [27:0]      pp_s, pp_c;
    logic [29:0]      tp_s, tp_c;
    logic [16:0]      csum, cdif;
    logic signed [27:0] xe, ye, we, he, a0, a1, a2, a3;
    logic signed [27:0] xmax, ymax;
    logic [3:0]       xneg, yneg, xhi, yhi;

    function automatic logic [25:0] mul_q14(input logic [22:0] v,
                                            input logic [16:0] k);
        logic signed [40:0] prod;
        logic [40:0]        mag;
        logic [40:0]        r;
        prod = $signed({1'b0, v}) * $signed(k);
        mag  = prod[40] ? 41'(-prod) : 41'(prod);
        r    = (mag + 41'd8192) >> 14;
        return prod[40] ? 26'(-r[25:0]) : r[25:0];
    endfunction

    function automatic logic [23:0] sat24(input logic signed [27:0] v);
        logic [23:0] r;
        if (v < -28'sd8388608) begin
            r = 24'h800000;
        end else if (v > 28'sd8388607) begin
            r = 24'h7FFFFF;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    assign en       = !(vld_reg[NST-1] && keep && q_full);
    assign in_ready = en;

    always_comb begin
        // Stage 0: capture the beat.
        st_next[0]       = st_reg[0];
        st_next[0].mode  = in_mode;
        st_next[0].x     = in_x;
        st_next[0].y     = in_y;
        st_next[0].z     = in_z;
        st_next[0].w     = in_w;
        st_next[0].h     = in_h;
        st_next[0].rz    = in_rz;
        st_next[0].alpha = in_alpha;
        st_next[0].rc    = in_rgb[23:16];
        st_next[0].gc    = in_rgb[15:8];
        st_next[0].bc    = in_rgb[7:0];
        st_next[0].inten = in_inten;
        st_next[0].phase = 16'(in_angle) << (16 - ANGLE_BITS);

        // Stage 1: quadrant folding and fade classification.
        st_next[1]       = st_reg[0];
        ph_c             = st_reg[0].phase + 16'h4000;
        st_next[1].ts    = st_reg[0].phase[14] ? 15'(15'd16384 - {1'b0, st_reg[0].phase[13:0]})
                                               : {1'b0, st_reg[0].phase[13:0]};
        st_next[1].tc    = ph_c[14] ? 15'(15'd16384 - {1'b0, ph_c[13:0]})
                                    : {1'b0, ph_c[13:0]};
        st_next[1].neg_s = st_reg[0].phase[15];
        st_next[1].neg_c = ph_c[15];
        st_next[1].fade  = (st_reg[0].mode == MODE_ROT_FADE) && (st_reg[0].z < 24'(FADE_HI));
        st_next[1].drop  = (st_reg[0].mode == MODE_ROT_FADE) && (st_reg[0].z < 24'(FADE_LO));
        fdz              = (FRAC_BITS+2)'(st_reg[0].z - 24'(FADE_LO));
        st_next[1].n     = NW'(fdz * 8'd255);

        // Stage 2: t squared, fade factor by reciprocal multiply.
        st_next[2]       = st_reg[1];
        sq_s             = st_reg[1].ts * st_reg[1].ts;
        sq_c             = st_reg[1].tc * st_reg[1].tc;
        st_next[2].t2s   = sq_s[28:14];
        st_next[2].t2c   = sq_c[28:14];
        fprod            = st_reg[1].n * FRECIP;
        st_next[2].f     = fprod[FK+7:FK];

        // Stage 3: first polynomial term, fade applied to the colour.
        st_next[3]       = st_reg[2];
        cp_s             = SIN_C * st_reg[2].t2s;
        cp_c             = SIN_C * st_reg[2].t2c;
        st_next[3].p1s   = 14'(SIN_B - 14'(cp_s[24:14]));
        st_next[3].p1c   = 14'(SIN_B - 14'(cp_c[24:14]));
        if (st_reg[2].fade) begin
            st_next[3].rc    = 8'((16'(st_reg[2].f) * st_reg[2].rc) >> 8);
            st_next[3].gc    = 8'((16'(st_reg[2].f) * st_reg[2].gc) >> 8);
            st_next[3].bc    = 8'((16'(st_reg[2].f) * st_reg[2].bc) >> 8);
            st_next[3].inten = 8'((16'(st_reg[2].f) * st_reg[2].inten) >> 8);
        end

        // Stage 4: second polynomial term, packed colour.
        st_next[4]       = st_reg[3];
        pp_s             = st_reg[3].p1s * st_reg[3].t2s;
        pp_c             = st_reg[3].p1c * st_reg[3].t2c;
        st_next[4].p2s   = 15'(SIN_A - 15'(pp_s[27:14]));
        st_next[4].p2c   = 15'(SIN_A - 15'(pp_c[27:14]));
        st_next[4].rgba  = {8'((16'(st_reg[3].rc) * st_reg[3].inten) >> 8),
                            8'((16'(st_reg[3].gc) * st_reg[3].inten) >> 8),
                            8'((16'(st_reg[3].bc) * st_reg[3].inten) >> 8),
                            st_reg[3].alpha};

        // Stage 5: final polynomial product and sign.
        st_next[5]       = st_reg[4];
        tp_s             = st_reg[4].ts * st_reg[4].p2s;
        tp_c             = st_reg[4].tc * st_reg[4].p2c;
        st_next[5].sn    = st_reg[4].neg_s ? 16'(-{1'b0, tp_s[28:14]}) : {1'b0, tp_s[28:14]};
        st_next[5].cs    = st_reg[4].neg_c ? 16'(-{1'b0, tp_c[28:14]}) : {1'b0, tp_c[28:14]};

        // Stage 6: size times sine/cosine terms, rounded.
        st_next[6]       = st_reg[5];
        csum             = {st_reg[5].cs[15], st_reg[5].cs} + {st_reg[5].sn[15], st_reg[5].sn};
        cdif             = {st_reg[5].cs[15], st_reg[5].cs} - {st_reg[5].sn[15], st_reg[5].sn};
        if (st_reg[5].mode == MODE_ROT_DIM) begin
            st_next[6].m0 = mul_q14(st_reg[5].w, {st_reg[5].cs[15], st_reg[5].cs});
            st_next[6].m1 = mul_q14(st_reg[5].h, {st_reg[5].sn[15], st_reg[5].sn});
            st_next[6].m2 = mul_q14(st_reg[5].h, {st_reg[5].cs[15], st_reg[5].cs});
            st_next[6].m3 = mul_q14(st_reg[5].w, {st_reg[5].sn[15], st_reg[5].sn});
        end else begin
            st_next[6].m0 = mul_q14(st_reg[5].w, csum);
            st_next[6].m1 = mul_q14(st_reg[5].w, cdif);
            st_next[6].m2 = mul_q14(st_reg[5].h, csum);
            st_next[6].m3 = mul_q14(st_reg[5].h, cdif);
        end

        // Stage 7: corners at full precision.
        st_next[7]       = st_reg[6];
        xe = $signed({{4{st_reg[6].x[23]}}, st_reg[6].x});
        ye = $signed({{4{st_reg[6].y[23]}}, st_reg[6].y});
        we = $signed({5'd0, st_reg[6].w});
        he = $signed({5'd0, st_reg[6].h});
        a0 = $signed({{2{st_reg[6].m0[25]}}, st_reg[6].m0});
        a1 = $signed({{2{st_reg[6].m1[25]}}, st_reg[6].m1});
        a2 = $signed({{2{st_reg[6].m2[25]}}, st_reg[6].m2});
        a3 = $signed({{2{st_reg[6].m3[25]}}, st_reg[6].m3});
        case (st_reg[6].mode)
            MODE_FLAT: begin
                st_next[7].xs = {28'(xe + we), 28'(xe + we), 28'(xe - we), 28'(xe - we)};
                st_next[7].ys = {28'(ye - he), 28'(ye + he), 28'(ye + he), 28'(ye - he)};
            end
            MODE_ROT_DIM: begin
                st_next[7].xs = {28'(xe + a0 - a1), 28'(xe + a0 + a1),
                                 28'(xe - a0 + a1), 28'(xe - a0 - a1)};
                st_next[7].ys = {28'(ye - a2 - a3), 28'(ye + a2 - a3),
                                 28'(ye + a2 + a3), 28'(ye - a2 + a3)};
            end
            default: begin
                st_next[7].xs = {28'(xe + a1), 28'(xe + a0), 28'(xe - a1), 28'(xe - a0)};
                st_next[7].ys = {28'(ye - a2), 28'(ye + a3), 28'(ye + a2), 28'(ye - a3)};
            end
        endcase
    end

    // Cull test on the last stage; the flat mode is never culled.
    always_comb begin
        xmax = $signed(28'({cfg.scr_w, {FRAC_BITS{1'b0}}}));
        ymax = $signed(28'({cfg.scr_h, {FRAC_BITS{1'b0}}}));
        for (int i = 0; i < 4; i++) begin
            xneg[i] = st_reg[NST-1].xs[i][27];
            yneg[i] = st_reg[NST-1].ys[i][27];
            xhi[i]  = $signed(st_reg[NST-1].xs[i]) > xmax;
            yhi[i]  = $signed(st_reg[NST-1].ys[i]) > ymax;
            q_data.xs[i] = sat24($signed(st_reg[NST-1].xs[i]));
            q_data.ys[i] = sat24($signed(st_reg[NST-1].ys[i]));
        end
        cull = (st_reg[NST-1].mode != MODE_FLAT) &&
               ((&xneg) || (&yneg) || (&xhi) || (&yhi));
        keep = !st_reg[NST-1].drop && !cull;
        q_data.z    = st_reg[NST-1].z;
        q_data.rz   = st_reg[NST-1].rz;
        q_data.rgba = st_reg[NST-1].rgba;
    end

    assign q_push = vld_reg[NST-1] && keep && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NST; i++) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

endmodule

FILE: src/sqs_queue.sv
// Short queue of kept sprites between the front end and the vertex emitter.
// Depends on sqs_pkg.
module sqs_queue import sqs_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  sprite_t push_data,
    output logic    full,
    input  logic    pop,
    output sprite_t pop_data,
    output logic    empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sprite_t         mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop) begin
                count_reg <= CW'(count_reg + 1'b1);
            end else if (pop && !push) begin
                count_reg <= CW'(count_reg - 1'b1);
            end
        end
    end

endmodule

FILE: src/sqs_back.sv
// Back end: maps camera depth to screen depth with a serial divider
// and emits the six vertices of each queued sprite. Depends on sqs_pkg.
`include "sprite_quad_setup_top_assert.svh"

module sqs_back import sqs_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    q_empty,
    input  sprite_t q_data,
    output logic    q_pop,
    output logic    out_valid,
    input  logic    out_ready,
    output vertex_t out_vert
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PART,
        ST_SUM,
        ST_DIV,
        ST_FIN,
        ST_EMIT
    } state_t;

    state_t       state_reg;
    sprite_t      ent_reg;
    logic [47:0]  num_reg, den_reg;
    logic [23:0]  m_reg;
    logic         neg_reg, degen_reg, sat_reg;
    logic [47:0]  plo_reg, phi_reg;
    logic [72:0]  rem_reg;
    logic [71:0]  dsh_reg;
    logic [24:0]  q_reg;
    logic [4:0]   bit_reg;
    logic [23:0]  sd_reg;
    logic [2:0]   beat_reg;
    logic         valid_reg;
    vertex_t      vert_reg;

    logic [24:0]  dz, dc, ds;
    logic [23:0]  dz_abs, dc_abs, ds_abs;
    logic [72:0]  n_full;
    logic         ge;
    logic [25:0]  term;
    logic signed [27:0] res;
    logic [1:0]   ci;

    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign out_valid = valid_reg;
    assign out_vert  = vert_reg;

    always_comb begin
        dz     = {1'b0, ent_reg.z} - {1'b0, cfg.near_clip};
        dc     = {1'b0, cfg.far_clip} - {1'b0, cfg.near_clip};
        ds     = {1'b0, cfg.far_sd} - {1'b0, cfg.near_sd};
        dz_abs = dz[24] ? 24'(-dz) : dz[23:0];
        dc_abs = dc[24] ? 24'(-dc) : dc[23:0];
        ds_abs = ds[24] ? 24'(-ds) : ds[23:0];
        n_full = {1'b0, phi_reg, 24'd0} + {25'd0, plo_reg};
        ge     = rem_reg >= {1'b0, dsh_reg};
        // Any term of 2^25 or more saturates the sum either way.
        term   = sat_reg ? 26'd33554432 : {1'b0, q_reg};
        res    = neg_reg ? $signed({4'd0, cfg.near_sd}) - $signed({2'd0, term})
                         : $signed({4'd0, cfg.near_sd}) + $signed({2'd0, term});
        ci     = corner_of(beat_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            beat_reg  <= '0;
        end else begin
            if (state_reg == ST_EMIT && (!valid_reg || out_ready)) begin
                valid_reg <= 1'b1;
            end else if (valid_reg && out_ready) begin
                valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        ent_reg   <= q_data;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    num_reg   <= dz_abs * cfg.far_clip;
                    den_reg   <= dc_abs * ent_reg.z;
                    m_reg     <= ds_abs;
                    neg_reg   <= dz[24] ^ dc[24] ^ ds[24];
                    degen_reg <= (ent_reg.z == '0) || (dc == '0);
                    state_reg <= ST_PART;
                end
                ST_PART: begin
                    plo_reg   <= num_reg[23:0] * m_reg;
                    phi_reg   <= num_reg[47:24] * m_reg;
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    rem_reg <= n_full;
                    dsh_reg <= {den_reg, 24'd0};
                    q_reg   <= '0;
                    bit_reg <= 5'd24;
                    if (n_full >= {den_reg, 25'd0}) begin
                        sat_reg   <= 1'b1;
                        state_reg <= ST_FIN;
                    end else begin
                        sat_reg   <= 1'b0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    // Restoring division, one quotient bit per cycle.
                    if (ge) begin
                        rem_reg <= rem_reg - {1'b0, dsh_reg};
                    end
                    q_reg   <= {q_reg[23:0], ge};
                    dsh_reg <= dsh_reg >> 1;
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == '0) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (degen_reg) begin
                        sd_reg <= cfg.near_sd;
                    end else if (res < 0) begin
                        sd_reg <= '0;
                    end else if (res > 28'sd16777215) begin
                        sd_reg <= 24'hFFFFFF;
                    end else begin
                        sd_reg <= res[23:0];
                    end
                    beat_reg  <= '0;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!valid_reg || out_ready) begin
                        vert_reg.x    <= ent_reg.xs[ci];
                        vert_reg.y    <= ent_reg.ys[ci];
                        vert_reg.sd   <= sd_reg;
                        vert_reg.cz   <= ent_reg.z;
                        vert_reg.rz   <= ent_reg.rz;
                        vert_reg.rgba <= ent_reg.rgba;
                        vert_reg.u    <= corner_u(ci);
                        vert_reg.v    <= corner_v(ci);
                        vert_reg.last <= (beat_reg == 3'd5);
                        beat_reg      <= beat_reg + 1'b1;
                        if (beat_reg == 3'd5) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `SQS_ASSERT_NOW(a_pop_idle, q_pop, state_reg == ST_IDLE, "queue popped while busy")
    `SQS_ASSERT_NOW(a_mid_beat, valid_reg && out_ready && !vert_reg.last,
        state_reg == ST_EMIT, "sprite left before all six vertices were loaded")
    `SQS_ASSERT_NEXT(a_div_exit, state_reg == ST_DIV,
        state_reg == ST_DIV || state_reg == ST_FIN, "divider left its loop early")

endmodule

FILE: src/sprite_quad_setup_top.sv
// Sprite quad setup: expands point sprites into six triangle-list vertices.
// Sprites are accepted on the s_ channel; each sprite is one beat with its
// mode on s_tuser. Vertices leave on the m_ channel, six beats per kept sprite,
// with m_tlast on the sixth. Sprites dropped by the near fade or culled off
// screen produce no beats. The cfg channel writes the six registers and is
// always ready; write only while no sprite is in flight.
// Path: eight front stages, the queue, then the depth mapping of the back end
// before the first vertex. The back end takes one sprite at a time: the serial
// divider of the depth mapper (one quotient bit per cycle) runs for it, unless
// the depth term saturates, followed by the six emit beats.
// The front stages run ahead and keep accepting until the queue fills.
// Reset is synchronous and clears all control state and the registers to
// their defaults. When m_tready is low the current vertex holds, the back end
// waits, the queue fills and then s_tready falls.
// Depends on sqs_pkg, sqs_front, sqs_queue and sqs_back.
module sprite_quad_setup_top import sqs_pkg::*; #(
    parameter int ANGLE_BITS  = ANGLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int S_DATA_W   = ((182 + ANGLE_BITS + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // centre_x, centre_y, view_depth, half_width, half_height, colour_rgb,
    // intensity, recip_depth, angle, alpha, zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    // mode
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // vertex_x, vertex_y, vertex_screen_depth, vertex_camera_depth,
    // vertex_recip_depth, vertex_rgba, tex_u, tex_v, zero fill
    output logic [159:0]        m_tdata,
    output logic                m_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_data
);

    cfg_t    cfg_reg;
    logic    q_push, q_full, q_pop, q_empty;
    sprite_t q_in, q_out;
    vertex_t vert;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.near_clip <= 24'd256;
            cfg_reg.far_clip  <= 24'd512000;
            cfg_reg.scr_w     <= 13'd640;
            cfg_reg.scr_h     <= 13'd480;
            cfg_reg.near_sd   <= 24'd0;
            cfg_reg.far_sd    <= 24'hFFFFFF;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_NEAR_CLIP: cfg_reg.near_clip <= cfg_data;
                CFG_FAR_CLIP:  cfg_reg.far_clip  <= cfg_data;
                CFG_SCR_W:     cfg_reg.scr_w     <= cfg_data[12:0];
                CFG_SCR_H:     cfg_reg.scr_h     <= cfg_data[12:0];
                CFG_NEAR_SD:   cfg_reg.near_sd   <= cfg_data;
                CFG_FAR_SD:    cfg_reg.far_sd    <= cfg_data;
                default: ;
            endcase
        end
    end

    sqs_front #(
        .ANGLE_BITS (ANGLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_mode  (s_tuser),
        .in_x     (s_tdata[23:0]),
        .in_y     (s_tdata[47:24]),
        .in_z     (s_tdata[71:48]),
        .in_w     (s_tdata[94:72]),
        .in_h     (s_tdata[117:95]),
        .in_rgb   (s_tdata[141:118]),
        .in_inten (s_tdata[149:142]),
        .in_rz    (s_tdata[173:150]),
        .in_angle (s_tdata[174+ANGLE_BITS-1:174]),
        .in_alpha (s_tdata[174+ANGLE_BITS+7:174+ANGLE_BITS]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    sqs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    sqs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_vert  (vert)
    );

    assign m_tdata = {6'd0, vert.v, vert.u, vert.rgba, vert.rz, vert.cz,
                      vert.sd, vert.y, vert.x};
    assign m_tlast = vert.last;

endmodule
